[rtl/core/bcdacc_pkg.sv]
// ----------------------------------------------------------------------------
// bcdacc_pkg
// shared types and constants of the decimal accumulator
// ----------------------------------------------------------------------------
package bcdacc_pkg;

   localparam int CMD_W   = 4;
   localparam int AMT_W   = 5;
   localparam int ORDER_W = 2;
   localparam int VALUE_W = 64;
   localparam int BIN_W   = 64;
   localparam int DIGIT_W = 4;

   // enough for a count of BIN_W dabble steps
   localparam int CNT_W = $clog2(BIN_W + 1);

   // command codes
   localparam logic [CMD_W-1:0] CMD_LOAD_BIN  = 4'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD_BCD  = 4'd1;
   localparam logic [CMD_W-1:0] CMD_ADD       = 4'd2;
   localparam logic [CMD_W-1:0] CMD_SUB       = 4'd3;
   localparam logic [CMD_W-1:0] CMD_CMP       = 4'd4;
   localparam logic [CMD_W-1:0] CMD_SHIFT_L   = 4'd5;
   localparam logic [CMD_W-1:0] CMD_SHIFT_R   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_INC       = 4'd7;
   localparam logic [CMD_W-1:0] CMD_DEC       = 4'd8;

   // compare outcome codes
   localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_LESS    = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_GREATER = 2'd2;

   // decimal digit constants
   localparam logic [DIGIT_W:0]   DEC_BASE  = 5'd10;
   localparam logic [DIGIT_W-1:0] DEC_MAX   = 4'd9;
   localparam logic [DIGIT_W-1:0] DD_LIMIT  = 4'd5;
   localparam logic [DIGIT_W-1:0] DD_ADJUST = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIGIT,
      ST_SHIFT,
      ST_DABBLE,
      ST_FINISH
   } state_type;

   // one step of the shared digit adder
   typedef struct packed {
      logic [DIGIT_W-1:0] a;
      logic [DIGIT_W-1:0] b;
      logic               cin;
      logic               sub;
   } digit_in_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] r;
      logic               cout;
   } digit_out_type;

endpackage

[rtl/core/bcdacc_digit_unit.sv]
// ----------------------------------------------------------------------------
// bcdacc_digit_unit
// one decimal digit add or subtract with carry / borrow
// ----------------------------------------------------------------------------
module bcdacc_digit_unit
   import bcdacc_pkg::*;
(
   input  digit_in_type  dig_in,
   output digit_out_type dig_out
);

   logic [DIGIT_W-1:0] b_clamp;
   logic [DIGIT_W:0]   a_ext;
   logic [DIGIT_W:0]   sum;
   logic [DIGIT_W:0]   sub_amt;

   // operand nibbles above nine read as nine
   assign b_clamp = (dig_in.b > DEC_MAX) ? DEC_MAX : dig_in.b;
   assign a_ext   = {1'b0, dig_in.a};
   assign sum     = a_ext + {1'b0, b_clamp} + {{DIGIT_W{1'b0}}, dig_in.cin};
   assign sub_amt = {1'b0, b_clamp} + {{DIGIT_W{1'b0}}, dig_in.cin};

   always_comb begin
      dig_out = '0;
      if (dig_in.sub) begin
         if (a_ext < sub_amt) begin
            dig_out.r    = DIGIT_W'(a_ext + DEC_BASE - sub_amt);
            dig_out.cout = 1'b1;
         end else begin
            dig_out.r    = DIGIT_W'(a_ext - sub_amt);
            dig_out.cout = 1'b0;
         end
      end else begin
         if (sum >= DEC_BASE) begin
            dig_out.r    = DIGIT_W'(sum - DEC_BASE);
            dig_out.cout = 1'b1;
         end else begin
            dig_out.r    = sum[DIGIT_W-1:0];
            dig_out.cout = 1'b0;
         end
      end
   end

endmodule

[rtl/core/bcdacc_dabble.sv]
// ----------------------------------------------------------------------------
// bcdacc_dabble
// one double-dabble step: add three to digits of five or more, then shift in
// one binary bit; the top bit falls off, which keeps the value modulo 10^n
// ----------------------------------------------------------------------------
module bcdacc_dabble
   import bcdacc_pkg::*;
#(
   parameter int DIGITS = 16
)
(
   input  logic [DIGITS*DIGIT_W-1:0] acc,
   input  logic                      bit_in,
   output logic [DIGITS*DIGIT_W-1:0] acc_next
);

   logic [DIGITS*DIGIT_W-1:0] adj;
   logic [DIGITS*DIGIT_W:0]   shifted;

   for (genvar i = 0; i < DIGITS; i++) begin : g_adj
      assign adj[i*DIGIT_W +: DIGIT_W] =
         (acc[i*DIGIT_W +: DIGIT_W] >= DD_LIMIT) ?
         acc[i*DIGIT_W +: DIGIT_W] + DD_ADJUST : acc[i*DIGIT_W +: DIGIT_W];
   end

   assign shifted  = {adj, bit_in};
   assign acc_next = shifted[DIGITS*DIGIT_W-1:0];

endmodule

[rtl/core/bcd_accumulator_alu.sv]
// ----------------------------------------------------------------------------
// bcd_accumulator_alu
// decimal accumulator of DIGITS packed bcd digits, one command per request
// ----------------------------------------------------------------------------
// The block holds a DIGITS-digit packed BCD accumulator (reset to zero) and
// answers every request with exactly one response carrying the accumulator
// after the command and, for compare, the order against the operand.
// Load bcd, add, subtract, compare, increment and decrement run digit-serial
// through one shared decimal digit adder, least significant digit first, the
// accumulator rotating and the operand shifting one digit per cycle. Load
// binary runs 64 double-dabble steps, one input bit a cycle. Digit shifts
// move one digit a cycle; a shift of zero and an unknown command leave the
// accumulator unchanged, and a shift of DIGITS or more clears it. The request
// side is stalled while a command is in progress; a finished response sits in
// an output register, so the next request can be taken while it waits.
// ----------------------------------------------------------------------------
module bcd_accumulator_alu
   import bcdacc_pkg::*;
#(
   parameter int DIGITS = 16
)
(
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [CMD_W-1:0]   req_command,
   input  logic [VALUE_W-1:0] req_operand_bcd,
   input  logic [BIN_W-1:0]   req_binary_value,
   input  logic [AMT_W-1:0]   req_shift_amount,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [VALUE_W-1:0] rsp_value_bcd,
   output logic [ORDER_W-1:0] rsp_order_result
);

   localparam int                 ACC_W      = DIGITS * DIGIT_W;
   localparam logic [AMT_W-1:0]   DIGITS_AMT = AMT_W'(DIGITS);
   localparam logic [CNT_W-1:0]   DIGITS_CNT = CNT_W'(DIGITS);
   localparam logic [CNT_W-1:0]   BIN_CNT    = CNT_W'(BIN_W);

   // sequencer state
   state_type           state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CMD_W-1:0]    cmd_ff, cmd_in;

   // working registers
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    opd_ff, opd_in;
   logic [BIN_W-1:0]    bin_ff, bin_in;
   logic                carry_ff, carry_in;
   logic                neq_ff, neq_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic [ORDER_W-1:0]  rsp_order_ff, rsp_order_in;

   // shared unit wiring
   digit_in_type        dig_in;
   digit_out_type       dig_out;
   logic [ACC_W-1:0]    dabble_acc;
   logic [ACC_W+DIGIT_W-1:0] rot_acc;
   logic [ACC_W+DIGIT_W-1:0] shl_acc;
   logic [ACC_W+DIGIT_W-1:0] shr_acc;
   logic [DIGIT_W-1:0]  wb_digit;
   logic [ACC_W-1:0]    acc_fin;
   logic                slot_free;

   bcdacc_digit_unit u_digit (
      .dig_in  (dig_in),
      .dig_out (dig_out)
   );

   bcdacc_dabble #(
      .DIGITS (DIGITS)
   ) u_dabble (
      .acc      (acc_ff),
      .bit_in   (bin_ff[BIN_W-1]),
      .acc_next (dabble_acc)
   );

   // operand of the digit unit for the current low digit
   always_comb begin
      dig_in     = '0;
      dig_in.a   = acc_ff[DIGIT_W-1:0];
      dig_in.cin = carry_ff;
      case (cmd_ff)
         CMD_LOAD_BCD: begin
            dig_in.a = '0;
            dig_in.b = opd_ff[DIGIT_W-1:0];
         end
         CMD_ADD: begin
            dig_in.b = opd_ff[DIGIT_W-1:0];
         end
         CMD_SUB, CMD_CMP: begin
            dig_in.b   = opd_ff[DIGIT_W-1:0];
            dig_in.sub = 1'b1;
         end
         CMD_DEC: begin
            dig_in.sub = 1'b1;
         end
         default: begin
            dig_in.b = '0;
         end
      endcase
   end

   // compare leaves the accumulator alone
   assign wb_digit = (cmd_ff == CMD_CMP) ? acc_ff[DIGIT_W-1:0] : dig_out.r;

   // rotate right one digit with the new digit entering at the top
   assign rot_acc = {wb_digit, acc_ff};
   assign shl_acc = {acc_ff, {DIGIT_W{1'b0}}};
   assign shr_acc = {{DIGIT_W{1'b0}}, acc_ff};

   // a final borrow on subtract means the operand was larger
   assign acc_fin   = (cmd_ff == CMD_SUB && carry_ff) ? '0 : acc_ff;
   assign slot_free = !(rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         cmd_ff       <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         cmd_ff       <= cmd_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      opd_ff       <= opd_in;
      bin_ff       <= bin_in;
      carry_ff     <= carry_in;
      neq_ff       <= neq_in;
      rsp_value_ff <= rsp_value_in;
      rsp_order_ff <= rsp_order_in;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      cmd_in       = cmd_ff;
      acc_in       = acc_ff;
      opd_in       = opd_ff;
      bin_in       = bin_ff;
      carry_in     = carry_ff;
      neq_in       = neq_ff;
      rsp_value_in = rsp_value_ff;
      rsp_order_in = rsp_order_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               opd_in   = req_operand_bcd[ACC_W-1:0];
               bin_in   = req_binary_value;
               carry_in = (req_command == CMD_INC) || (req_command == CMD_DEC);
               neq_in   = 1'b0;
               cnt_in   = DIGITS_CNT;
               case (req_command)
                  CMD_LOAD_BIN: begin
                     acc_in   = '0;
                     cnt_in   = BIN_CNT;
                     state_in = ST_DABBLE;
                  end
                  CMD_LOAD_BCD, CMD_ADD, CMD_SUB, CMD_CMP, CMD_INC, CMD_DEC: begin
                     state_in = ST_DIGIT;
                  end
                  CMD_SHIFT_L, CMD_SHIFT_R: begin
                     if (req_shift_amount == '0) begin
                        state_in = ST_FINISH;
                     end else if (req_shift_amount >= DIGITS_AMT) begin
                        // everything shifted out
                        acc_in   = '0;
                        state_in = ST_FINISH;
                     end else begin
                        cnt_in   = CNT_W'(req_shift_amount);
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                     // unknown command: report unchanged accumulator
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_DIGIT: begin
            acc_in   = rot_acc[ACC_W+DIGIT_W-1:DIGIT_W];
            opd_in   = opd_ff >> DIGIT_W;
            carry_in = dig_out.cout;
            neq_in   = neq_ff || (dig_out.r != '0);
            cnt_in   = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_SHIFT: begin
            if (cmd_ff == CMD_SHIFT_L) begin
               acc_in = shl_acc[ACC_W-1:0];
            end else begin
               acc_in = shr_acc[ACC_W+DIGIT_W-1:DIGIT_W];
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_DABBLE: begin
            acc_in = dabble_acc;
            bin_in = bin_ff << 1;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            // hold here until the response register can take the result
            if (slot_free) begin
               acc_in       = acc_fin;
               rsp_value_in = VALUE_W'(acc_fin);
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_CMP) begin
                  if (carry_ff) begin
                     rsp_order_in = ORDER_LESS;
                  end else if (neq_ff) begin
                     rsp_order_in = ORDER_GREATER;
                  end else begin
                     rsp_order_in = ORDER_EQUAL;
                  end
               end else begin
                  rsp_order_in = ORDER_EQUAL;
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_value_bcd    = rsp_value_ff;
   assign rsp_order_result = rsp_order_ff;

endmodule
